// ===== design/gcp_pkg.sv =====
// Package for the genotype call packer: payload types, allele table entry,
// register indexes and character constants. No dependencies.
package gcp_pkg;

    localparam int ASSAY_W    = 10;
    localparam int DEPTH_W    = 16;
    localparam int CEIL_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CALL_FORMAT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CEILING = 1'd1;

    localparam logic [7:0]        CHAR_DELETION = 8'h44;
    localparam logic [7:0]        CHAR_NO_CALL  = 8'h4E;
    localparam logic [7:0]        REJECT_BYTE   = 8'hFC;
    localparam logic [CEIL_W-1:0] CEILING_MAX   = 6'd62;
    localparam logic [CEIL_W-1:0] CEILING_RESET = 6'd10;
    localparam logic [1:0]        MAX_ALLELES   = 2'd2;

    localparam logic [1:0] CODE_NONE  = 2'b00;
    localparam logic [1:0] CODE_HOM_A = 2'b01;
    localparam logic [1:0] CODE_HOM_B = 2'b10;
    localparam logic [1:0] CODE_HET   = 2'b11;

    typedef struct packed {
        logic [ASSAY_W-1:0]       assay_index;
        logic                     call_present;
        logic [7:0]               first_allele;
        logic                     has_second;
        logic [7:0]               second_allele;
        logic signed [DEPTH_W-1:0] depth_value;
        logic                     row_end;
    } call_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       bad_allele;
    } result_t;

    typedef struct packed {
        logic [1:0] seen;
        logic [7:0] allele_a;
        logic [7:0] allele_b;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   allele;
        logic   full;
    } lookup_t;

    function automatic lookup_t lookup_allele(entry_t e, logic [7:0] ch);
        lookup_t r;
        r.entry  = e;
        r.allele = 1'b0;
        r.full   = 1'b0;
        if (e.seen != 2'd0 && e.allele_a == ch) begin
            r.allele = 1'b0;
        end
        else if (e.seen >= MAX_ALLELES && e.allele_b == ch) begin
            r.allele = 1'b1;
        end
        else if (e.seen < MAX_ALLELES) begin
            if (e.seen == 2'd0) begin
                r.entry.allele_a = ch;
            end
            else begin
                r.entry.allele_b = ch;
            end
            r.entry.seen = e.seen + 2'd1;
            r.allele     = e.seen[0];
        end
        else begin
            r.full = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== design/gcp_call_if.sv =====
// Input word channel of the genotype call packer.
// Depends on gcp_pkg.
interface gcp_call_if;
    logic          valid;
    logic          ready;
    gcp_pkg::call_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/gcp_result_if.sv =====
// Output word channel of the genotype call packer.
// Depends on gcp_pkg.
interface gcp_result_if;
    logic             valid;
    logic             ready;
    gcp_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/gcp_cfg_if.sv =====
// Register write channel of the genotype call packer.
// Depends on gcp_pkg.
interface gcp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [gcp_pkg::CFG_IDX_W-1:0]    index;
    logic [gcp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/genotype_call_packer.sv =====
// Genotype call packer top level: allele table memory, call encoder, 2-bit packer.
// Depends on gcp_pkg, gcp_call_if, gcp_result_if, gcp_cfg_if.
//
// Takes one genotype call word per cycle unless the result output stalls, and returns packed
// call bytes. A call word is taken into a register together with the allele table entry read
// at its assay; when that register fires, the call is encoded, the entry is written back and,
// if a byte is due, the result register is loaded. The sustained rate is one call per cycle
// while results are taken, set by the single read-modify-write of the allele table (a
// back-to-back call to the same assay takes the just-written entry from a bypass). After
// reset the table is swept to zero, one entry per cycle, over all NUM_ASSAYS entries (1024
// by default); call.ready stays low during the sweep. Register writes are always ready.
module genotype_call_packer #(
    parameter int NUM_ASSAYS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    gcp_call_if.sink     call,
    gcp_result_if.source result,
    gcp_cfg_if.sink      cfg
);

    localparam int AW = (NUM_ASSAYS > 1) ? $clog2(NUM_ASSAYS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ASSAYS - 1);

    gcp_pkg::entry_t mem [NUM_ASSAYS];

    logic                          fmt_reg;
    logic [gcp_pkg::CEIL_W-1:0]    ceil_reg;

    logic                          clr_active_reg;
    logic [AW-1:0]                 clr_addr_reg;

    logic                          s1_valid_reg;
    gcp_pkg::call_t                s1_call_reg;
    logic [AW-1:0]                 s1_addr_reg;
    gcp_pkg::entry_t               rd_data_reg;
    logic                          fwd_hit_reg;
    gcp_pkg::entry_t               fwd_data_reg;

    logic [7:0]                    pack_byte_reg;
    logic [1:0]                    pack_slot_reg;
    logic                          pend_err_reg;

    logic                          out_valid_reg;
    gcp_pkg::result_t              out_data_reg;

    logic [gcp_pkg::ASSAY_W-1:0]   rem;
    logic [AW-1:0]                 rd_addr;
    logic                          accept;
    logic                          s1_fire;
    logic                          fwd_hit_next;

    gcp_pkg::entry_t               entry_cur;
    gcp_pkg::entry_t               entry_new;
    gcp_pkg::lookup_t              lk1;
    gcp_pkg::lookup_t              lk2;
    logic                          nocall;
    logic                          bad;
    logic                          m2;
    logic [1:0]                    code;
    logic [gcp_pkg::CEIL_W-1:0]    ceil_eff;
    logic [gcp_pkg::CEIL_W-1:0]    depth_clamped;
    logic [7:0]                    fmt1_byte;
    logic [7:0]                    slot_bits;
    logic [7:0]                    pack_byte_next;
    logic [1:0]                    pack_slot_next;
    logic                          pend_err_next;
    logic                          emit;
    logic                          out_valid_next;
    gcp_pkg::result_t              out_data_next;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    gcp_pkg::entry_t               wr_data;

    // Reduce the assay number modulo NUM_ASSAYS
    always_comb
    begin
        rem = call.data.assay_index;
        for (int k = gcp_pkg::ASSAY_W - 1; k >= 0; k--)
        begin
            if ((32'(NUM_ASSAYS) << k) <= 32'(rem))
            begin
                rem = rem - gcp_pkg::ASSAY_W'(32'(NUM_ASSAYS) << k);
            end
        end
    end

    assign rd_addr = AW'(rem);

    assign s1_fire    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign call.ready = !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign accept     = call.valid && call.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= 1'b0;
            ceil_reg <= gcp_pkg::CEILING_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                gcp_pkg::REG_CALL_FORMAT:   fmt_reg  <= cfg.data[0];
                gcp_pkg::REG_DEPTH_CEILING: ceil_reg <= cfg.data[gcp_pkg::CEIL_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Encode the held call against its table entry
    always_comb
    begin
        entry_cur = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        nocall    = !s1_call_reg.call_present
                    || s1_call_reg.first_allele == gcp_pkg::CHAR_DELETION
                    || s1_call_reg.first_allele == gcp_pkg::CHAR_NO_CALL;
        lk1       = gcp_pkg::lookup_allele(entry_cur, s1_call_reg.first_allele);
        lk2       = gcp_pkg::lookup_allele(lk1.entry, s1_call_reg.second_allele);
        bad       = !nocall && (lk1.full || (s1_call_reg.has_second && lk2.full));
        entry_new = nocall ? entry_cur
                           : (s1_call_reg.has_second ? lk2.entry : lk1.entry);
        m2        = s1_call_reg.has_second ? lk2.allele : lk1.allele;
        if (nocall || bad)
        begin
            code = gcp_pkg::CODE_NONE;
        end
        else if (!lk1.allele && !m2)
        begin
            code = gcp_pkg::CODE_HOM_A;
        end
        else if (lk1.allele && m2)
        begin
            code = gcp_pkg::CODE_HOM_B;
        end
        else
        begin
            code = gcp_pkg::CODE_HET;
        end

        ceil_eff = (ceil_reg > gcp_pkg::CEILING_MAX) ? gcp_pkg::CEILING_MAX : ceil_reg;
        if (s1_call_reg.depth_value < 0)
        begin
            depth_clamped = '0;
        end
        else if (s1_call_reg.depth_value > $signed({10'd0, ceil_eff}))
        begin
            depth_clamped = ceil_eff;
        end
        else
        begin
            depth_clamped = s1_call_reg.depth_value[gcp_pkg::CEIL_W-1:0];
        end

        if (bad)
        begin
            fmt1_byte = gcp_pkg::REJECT_BYTE;
        end
        else if (code == gcp_pkg::CODE_NONE)
        begin
            fmt1_byte = '0;
        end
        else
        begin
            fmt1_byte = {depth_clamped, code};
        end

        case (pack_slot_reg)
            2'd0:    slot_bits = {code, 6'd0};
            2'd1:    slot_bits = {2'd0, code, 4'd0};
            2'd2:    slot_bits = {4'd0, code, 2'd0};
            default: slot_bits = {6'd0, code};
        endcase

        pack_byte_next = pack_byte_reg | slot_bits;
        pack_slot_next = pack_slot_reg + 2'd1;
        pend_err_next  = pend_err_reg || bad;
        emit           = fmt_reg || pack_slot_next == 2'd0 || s1_call_reg.row_end;

        if (fmt_reg)
        begin
            out_data_next.out_byte   = fmt1_byte;
            out_data_next.bad_allele = 1'b0;
        end
        else
        begin
            out_data_next.out_byte   = pack_byte_next;
            out_data_next.bad_allele = pend_err_next;
        end

        if (s1_fire)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
        end

        if (accept)
        begin
            fwd_hit_next = s1_fire && s1_addr_reg == rd_addr;
        end
        else
        begin
            fwd_hit_next = fwd_hit_reg && !s1_fire;
        end
    end

    assign wr_en   = clr_active_reg || s1_fire;
    assign wr_addr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign wr_data = clr_active_reg ? '0 : entry_new;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_call_reg  <= call.data;
            s1_addr_reg  <= rd_addr;
            fwd_data_reg <= entry_new;
        end
        if (s1_fire && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pack_byte_reg <= '0;
            pack_slot_reg <= '0;
            pend_err_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept || (s1_valid_reg && !s1_fire);
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire && !fmt_reg)
            begin
                if (emit)
                begin
                    pack_byte_reg <= '0;
                    pack_slot_reg <= '0;
                    pend_err_reg  <= 1'b0;
                end
                else
                begin
                    pack_byte_reg <= pack_byte_next;
                    pack_slot_reg <= pack_slot_next;
                    pend_err_reg  <= pend_err_next;
                end
            end
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg)
        else $error("call in flight during table sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted call lost before encoding");

    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("bypass active with no call held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !fmt_reg && emit) |=> (pack_slot_reg == 2'd0 && !pend_err_reg))
        else $error("packer not restarted after emitted byte");
`endif

endmodule
